// ----- rtl/class_aware_box_suppression_defines.svh -----
// Assertion macros for the box suppression block.
// Used by the controller and the top level; no other dependencies.
`ifndef CLASS_AWARE_BOX_SUPPRESSION_DEFINES_SVH
`define CLASS_AWARE_BOX_SUPPRESSION_DEFINES_SVH
`ifndef SYNTH
`define CABS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CABS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CABS_ASSERT(label, clk, rst_n, prop, msg)
`define CABS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/cabs_pkg.sv -----
// Shared types and constants for the box suppression block.
// No dependencies.
package cabs_pkg;
	localparam int unsigned SCORE_BITS = 16;
	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned CLS_PORT_BITS = 8;
	localparam logic [15:0] IOU_THR_RESET = 16'd29491;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // latch arriving box
		OP_SCAN,     // read entry at index for insertion search
		OP_SHIFT_RD, // read entry k-1
		OP_SHIFT_WR, // write read entry to k
		OP_INSERT,   // write new box at position
		OP_RD_I,     // read candidate i
		OP_RD_J,     // read reference j
		OP_IOU1,     // stage 1 of overlap test
		OP_IOU2,     // stage 2 of overlap test
		OP_MARK,     // write kept mark for i
		OP_EMIT_RD   // read entry for output
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [6:0] idx;
		logic       keep;
	} dp_cmd_t;

	typedef struct packed {
		logic score_ge;   // stored score >= new score
		logic same_class; // class of i equals class of j
		logic ref_kept;   // mark of j
		logic suppress;   // overlap exceeds threshold
		logic cur_kept;   // mark of entry just read for emit
		logic new_zero;   // latched box has zero score
	} dp_stat_t;
endpackage

// ----- rtl/cabs_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module cabs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/cabs_datapath.sv -----
// Datapath: box stores, new-box register, overlap test, output fields.
// Depends on cabs_pkg and cabs_ram.
module cabs_datapath #(
	parameter int unsigned MAX_BOXES = 64,
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned CLASS_BITS = 8
) (
	input  logic                          clk,
	input  cabs_pkg::dp_cmd_t             cmd,
	input  logic [15:0]                   thr,
	input  logic [15:0]                   in_x1,
	input  logic [15:0]                   in_y1,
	input  logic [15:0]                   in_x2,
	input  logic [15:0]                   in_y2,
	input  logic [15:0]                   in_score,
	input  logic [7:0]                    in_class,
	output cabs_pkg::dp_stat_t            stat,
	output logic [4*COORD_BITS-1:0]       rd_corners,
	output logic [15:0]                   rd_score,
	output logic [CLASS_BITS-1:0]         rd_class
);
	import cabs_pkg::*;
	localparam int unsigned AW = $clog2(MAX_BOXES);
	localparam int unsigned CW = 4 * COORD_BITS;
	localparam int unsigned EW = CW + SCORE_BITS + CLASS_BITS;
	localparam int unsigned AR = 2 * COORD_BITS + 2;

	// new box register
	logic [CW-1:0]         new_c_q;
	logic [15:0]           new_s_q;
	logic [CLASS_BITS-1:0] new_k_q;
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			new_c_q <= {in_y2[COORD_BITS-1:0], in_x2[COORD_BITS-1:0],
				in_y1[COORD_BITS-1:0], in_x1[COORD_BITS-1:0]};
			new_s_q <= in_score;
			new_k_q <= in_class[CLASS_BITS-1:0];
		end
	end

	// entry store and mark store
	logic          we, mwe;
	logic [EW-1:0] wdata, rdata;
	logic          mark_rd;
	logic [AW-1:0] addr;
	assign addr  = cmd.idx[AW-1:0];
	assign we    = (cmd.op == OP_SHIFT_WR) || (cmd.op == OP_INSERT);
	assign mwe   = (cmd.op == OP_MARK);
	assign wdata = (cmd.op == OP_INSERT) ? {new_k_q, new_s_q, new_c_q} : rdata;

	cabs_ram #(.WIDTH(EW), .DEPTH(MAX_BOXES)) u_ent (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));
	cabs_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_mark (
		.clk(clk), .we(mwe), .addr(addr), .wdata(cmd.keep), .rdata(mark_rd));

	logic [CW-1:0]         r_c;
	logic [15:0]           r_s;
	logic [CLASS_BITS-1:0] r_k;
	assign {r_k, r_s, r_c} = rdata;
	assign rd_corners = r_c;
	assign rd_score   = r_s;
	assign rd_class   = r_k;

	// candidate box register, loaded from the registered RAM read of OP_RD_I, flagged by rd_i_q
	logic [CW-1:0]         cand_c_q;
	logic [CLASS_BITS-1:0] cand_k_q;
	logic                  rd_i_q;
	always_ff @(posedge clk) begin
		rd_i_q <= (cmd.op == OP_RD_I);
		if (rd_i_q) begin
			cand_c_q <= r_c;
			cand_k_q <= r_k;
		end
	end

	// overlap stage 1: widths, heights, areas
	logic [COORD_BITS-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, ix1, iy1, ix2, iy2;
	assign {ay2, ax2, ay1, ax1} = cand_c_q;
	assign {by2, bx2, by1, bx1} = r_c;
	assign ix1 = (ax1 > bx1) ? ax1 : bx1;
	assign iy1 = (ay1 > by1) ? ay1 : by1;
	assign ix2 = (ax2 < bx2) ? ax2 : bx2;
	assign iy2 = (ay2 < by2) ? ay2 : by2;

	logic                  ovl_s1;
	logic [COORD_BITS-1:0] iw_s1, ih_s1;
	logic [2*COORD_BITS-1:0] area_a_s1, area_b_s1;
	logic                  aval_s1, bval_s1;
	always_ff @(posedge clk) begin
		if (cmd.op == OP_IOU1) begin
			ovl_s1 <= (ix1 < ix2) && (iy1 < iy2);
			iw_s1  <= ix2 - ix1;
			ih_s1  <= iy2 - iy1;
			// inverted boxes have negative area; keep sign via flag
			aval_s1 <= (ax2 >= ax1) == (ay2 >= ay1);
			bval_s1 <= (bx2 >= bx1) == (by2 >= by1);
			area_a_s1 <= ((ax2 >= ax1) ? ax2 - ax1 : ax1 - ax2)
				* ((ay2 >= ay1) ? ay2 - ay1 : ay1 - ay2);
			area_b_s1 <= ((bx2 >= bx1) ? bx2 - bx1 : bx1 - bx2)
				* ((by2 >= by1) ? by2 - by1 : by1 - by2);
		end
	end

	// stage 2: intersection and union (signed), then threshold compare
	logic [2*COORD_BITS-1:0] inter;
	logic signed [AR:0]      uni;
	logic signed [AR:0]      sa, sb;
	assign inter = iw_s1 * ih_s1;
	assign sa = aval_s1 ? $signed({2'b00, area_a_s1}) : -$signed({2'b00, area_a_s1});
	assign sb = bval_s1 ? $signed({2'b00, area_b_s1}) : -$signed({2'b00, area_b_s1});
	assign uni = sa + sb - $signed({2'b00, inter});

	logic                    ovl_s2, upos_s2;
	logic [2*COORD_BITS-1:0] inter_s2;
	logic [AR-1:0]           uni_s2;
	always_ff @(posedge clk) begin
		if (cmd.op == OP_IOU2) begin
			ovl_s2   <= ovl_s1;
			upos_s2  <= uni > 0;
			inter_s2 <= inter;
			uni_s2   <= uni[AR-1:0];
		end
	end

	logic [AR+15:0] rhs;
	logic [2*COORD_BITS+15:0] lhs;
	assign rhs = thr * uni_s2;
	assign lhs = {inter_s2, 16'd0};

	always_comb begin
		stat.score_ge   = (r_s >= new_s_q);
		stat.same_class = (r_k == cand_k_q);
		stat.ref_kept   = mark_rd;
		stat.suppress   = ovl_s2 && upos_s2
			&& ({{(AR-2*COORD_BITS){1'b0}}, lhs} > rhs);
		stat.cur_kept   = mark_rd;
		stat.new_zero   = (new_s_q == '0);
	end
endmodule

// ----- rtl/cabs_ctrl.sv -----
// Controller: insertion walk, suppression loops and result sequencing.
// Depends on cabs_pkg and the assertion macro header.
`include "class_aware_box_suppression_defines.svh"
module cabs_ctrl #(
	parameter int unsigned MAX_BOXES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               final_in,
	input  logic [15:0]        in_score,
	output logic               busy,
	output cabs_pkg::dp_cmd_t  cmd,
	input  cabs_pkg::dp_stat_t stat,
	output logic               res_valid,
	output logic               res_last,
	output logic               res_none,
	output logic               res_ovf
);
	import cabs_pkg::*;
	localparam int unsigned CNTW = $clog2(MAX_BOXES + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
		S_SRD = 4'd3, S_SWAIT = 4'd4, S_SWR = 4'd5, S_INS = 4'd6,
		S_RDI = 4'd7, S_RDJ = 4'd8, S_CHK = 4'd9, S_I1 = 4'd10,
		S_I2 = 4'd11, S_DEC = 4'd12, S_MARK = 4'd13, S_EMIT = 4'd14,
		S_EOUT = 4'd15;

	logic [3:0]      state_q;
	logic [CNTW-1:0] cnt_q, i_q, j_q, pos_q, k_q, kept_q, emitted_q;
	logic            ovf_q, fin_q, keep_q, zero_q, iou_done_q;

	assign busy = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd.op = OP_NONE;
		cmd.idx = '0;
		cmd.keep = keep_q;
		unique case (state_q)
			S_IDLE:  begin cmd.op = start ? OP_LOAD : OP_NONE; end
			S_SCAN:  begin cmd.op = OP_SCAN; cmd.idx = 7'(pos_q); end
			S_SCANW: begin cmd.op = OP_NONE; cmd.idx = 7'(pos_q); end
			S_SRD:   begin cmd.op = OP_SHIFT_RD; cmd.idx = 7'(k_q - 1'b1); end
			S_SWAIT: begin cmd.op = OP_NONE; cmd.idx = 7'(k_q - 1'b1); end
			S_SWR:   begin cmd.op = OP_SHIFT_WR; cmd.idx = 7'(k_q); end
			S_INS:   begin cmd.op = OP_INSERT; cmd.idx = 7'(pos_q); end
			S_RDI:   begin cmd.op = OP_RD_I; cmd.idx = 7'(i_q); end
			S_RDJ:   begin cmd.op = OP_RD_J; cmd.idx = 7'(j_q); end
			S_CHK:   begin cmd.op = OP_NONE; cmd.idx = 7'(j_q); end
			S_I1:    begin cmd.op = OP_IOU1; cmd.idx = 7'(j_q); end
			S_I2:    begin cmd.op = OP_IOU2; cmd.idx = 7'(j_q); end
			S_DEC:   begin cmd.op = OP_NONE; cmd.idx = 7'(j_q); end
			S_MARK:  begin cmd.op = OP_MARK; cmd.idx = 7'(i_q); end
			S_EMIT:  begin cmd.op = OP_EMIT_RD; cmd.idx = 7'(i_q); end
			S_EOUT:  begin cmd.op = OP_NONE; cmd.idx = 7'(i_q); end
			default: begin cmd.op = OP_NONE; end
		endcase
	end

	// results: strobe on S_EOUT when mark set, or the none-kept result
	logic emit_now, none_now;
	assign emit_now = (state_q == S_EOUT) && stat.cur_kept && (kept_q != '0);
	assign none_now = (state_q == S_EOUT) && (kept_q == '0);
	assign res_valid = emit_now || none_now;
	assign res_none  = none_now;
	assign res_last  = none_now || (emit_now && (emitted_q + 1'b1 == kept_q));
	assign res_ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0; i_q <= '0; j_q <= '0; pos_q <= '0; k_q <= '0;
			kept_q <= '0; emitted_q <= '0;
			ovf_q <= 1'b0; fin_q <= 1'b0; keep_q <= 1'b0; zero_q <= 1'b0;
			iou_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						fin_q  <= final_in;
						zero_q <= (in_score == '0);
						pos_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// decide drop / overflow before walking
					priority if (zero_q) begin
						state_q <= fin_q ? S_RDI : S_IDLE;
						i_q <= '0; kept_q <= '0;
					end else if (cnt_q == CNTW'(MAX_BOXES)) begin
						ovf_q <= 1'b1;
						state_q <= fin_q ? S_RDI : S_IDLE;
						i_q <= '0; kept_q <= '0;
					end else if (pos_q == cnt_q) begin
						k_q <= cnt_q;
						state_q <= S_INS;
					end else begin
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (stat.score_ge) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						k_q <= cnt_q;
						state_q <= (cnt_q == pos_q) ? S_INS : S_SRD;
					end
				end
				S_SRD:   state_q <= S_SWAIT;
				S_SWAIT: state_q <= S_SWR;
				S_SWR: begin
					k_q <= k_q - 1'b1;
					state_q <= (k_q - 1'b1 == pos_q) ? S_INS : S_SRD;
				end
				S_INS: begin
					cnt_q <= cnt_q + 1'b1;
					i_q <= '0; kept_q <= '0;
					state_q <= fin_q ? S_RDI : S_IDLE;
				end
				S_RDI: begin
					if (i_q == cnt_q) begin
						i_q <= '0; emitted_q <= '0;
						state_q <= S_EMIT;
					end else begin
						j_q <= '0; keep_q <= 1'b1;
						state_q <= (i_q == '0) ? S_MARK : S_RDJ;
					end
				end
				S_RDJ: state_q <= S_CHK;
				S_CHK: begin
					// candidate ready; stats for j visible now
					if (stat.ref_kept && stat.same_class) begin
						state_q <= S_I1;
					end else begin
						state_q <= S_DEC;
					end
				end
				S_I1: state_q <= S_I2;
				S_I2: begin
					iou_done_q <= 1'b1;
					state_q <= S_DEC;
				end
				S_DEC: begin
					// overlap result only counts when the pair was tested
					iou_done_q <= 1'b0;
					if (iou_done_q && stat.suppress) begin
						keep_q <= 1'b0;
						state_q <= S_MARK;
					end else if (j_q + 1'b1 == i_q) begin
						state_q <= S_MARK;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_RDJ;
					end
				end
				S_MARK: begin
					if (keep_q) kept_q <= kept_q + 1'b1;
					i_q <= i_q + 1'b1;
					state_q <= S_RDI;
				end
				S_EMIT: state_q <= S_EOUT;
				S_EOUT: begin
					if (emit_now) emitted_q <= emitted_q + 1'b1;
					if (res_last || (i_q + 1'b1 >= cnt_q) ) begin
						state_q <= S_IDLE;
						cnt_q <= '0; ovf_q <= 1'b0; kept_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CABS_ASSERT(a_cnt_cap, clk, arst_n, cnt_q <= CNTW'(MAX_BOXES), "box count beyond capacity")
	`CABS_ASSERT(a_res_busy, clk, arst_n, res_valid |-> busy, "result while idle")
	`CABS_ASSERT(a_last_idle, clk, arst_n, res_last |=> !busy, "not idle after last result")
	`CABS_ASSERT(a_kept_cnt, clk, arst_n, kept_q <= cnt_q, "kept count above box count")
endmodule

// ----- rtl/class_aware_box_suppression.sv -----
// Top level of class-aware greedy box suppression.
// Depends on cabs_pkg, cabs_ctrl, cabs_datapath, cabs_ram.
// Insertion scans from index 0 to the first lower score, shifts lower entries down and
// writes the box. On the final item each entry is overlap-tested against earlier kept
// boxes of its class, then kept ones are read out. One item at a time, no receiver stall.
// Reset clears control and count; stores are undefined; threshold resets to 29491.
`include "class_aware_box_suppression_defines.svh"
module class_aware_box_suppression #(
	parameter int unsigned MAX_BOXES = 64,
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned CLASS_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic [15:0] box_x1,
	input  logic [15:0] box_y1,
	input  logic [15:0] box_x2,
	input  logic [15:0] box_y2,
	input  logic [15:0] score,
	input  logic [7:0]  class_index,
	input  logic        final_box,
	output logic        result_valid,
	output logic [15:0] out_x1,
	output logic [15:0] out_y1,
	output logic [15:0] out_x2,
	output logic [15:0] out_y2,
	output logic [15:0] out_score,
	output logic [7:0]  out_class,
	output logic        last_result,
	output logic        none_kept,
	output logic        overflowed
);
	import cabs_pkg::*;

	// threshold register, written only while no item is in flight
	logic [15:0] thr_q;
	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IOU_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [4*COORD_BITS-1:0] rc;
	logic [15:0]             rs;
	logic [CLASS_BITS-1:0]   rk;
	logic rv, rl, rn, ro;

	cabs_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .final_in(final_box),
		.in_score(score), .busy(busy), .cmd(cmd), .stat(stat),
		.res_valid(rv), .res_last(rl), .res_none(rn), .res_ovf(ro));

	cabs_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS),
		.CLASS_BITS(CLASS_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .thr(thr_q), .in_x1(box_x1), .in_y1(box_y1),
		.in_x2(box_x2), .in_y2(box_y2), .in_score(score), .in_class(class_index),
		.stat(stat), .rd_corners(rc), .rd_score(rs), .rd_class(rk));

	// output fields, zero on the none-kept result
	assign result_valid = rv;
	assign last_result  = rl;
	assign none_kept    = rn;
	assign overflowed   = ro;
	assign out_x1    = rn ? '0 : 16'(rc[COORD_BITS-1:0]);
	assign out_y1    = rn ? '0 : 16'(rc[2*COORD_BITS-1:COORD_BITS]);
	assign out_x2    = rn ? '0 : 16'(rc[3*COORD_BITS-1:2*COORD_BITS]);
	assign out_y2    = rn ? '0 : 16'(rc[4*COORD_BITS-1:3*COORD_BITS]);
	assign out_score = rn ? '0 : rs;
	assign out_class = rn ? '0 : 8'(rk);

	`CABS_ASSERT(a_none_last, clk, arst_n, none_kept |-> last_result, "none without last")
	`CABS_ASSERT(a_none_zero, clk, arst_n, none_kept |-> (out_score == '0), "none with score")
	`CABS_ASSERT(a_kept_score, clk, arst_n, (result_valid && !none_kept) |-> (out_score != '0),
		"kept box with zero score")
endmodule
